// ----- design/dhoat_pkg.sv -----
package dhoat_pkg;

   localparam logic [1:0] REQ_INSERT = 2'd0;
   localparam logic [1:0] REQ_DELETE = 2'd1;
   localparam logic [1:0] REQ_SEARCH = 2'd2;

   localparam logic [2:0] ST_INSERTED = 3'd0;
   localparam logic [2:0] ST_UPDATED  = 3'd1;
   localparam logic [2:0] ST_DELETED  = 3'd2;
   localparam logic [2:0] ST_FOUND    = 3'd3;
   localparam logic [2:0] ST_NOTFOUND = 3'd4;
   localparam logic [2:0] ST_FULL     = 3'd5;

   localparam int HASH_STEPS = 6;
   // reciprocal product, then remainder
   localparam int MOD_STEPS  = 2;

   localparam logic [31:0] MIX_C0 = 32'h7ed55d16;
   localparam logic [31:0] MIX_C1 = 32'hc761c23c;
   localparam logic [31:0] MIX_C2 = 32'h165667b1;
   localparam logic [31:0] MIX_C3 = 32'hd3a2646c;
   localparam logic [31:0] MIX_C4 = 32'hfd7046c5;
   localparam logic [31:0] MIX_C5 = 32'hb55a4f09;

   // slot state memory word: {used, tombstone}
   localparam logic [1:0] SLOT_EMPTY = 2'b00;
   localparam logic [1:0] SLOT_TOMB  = 2'b01;
   localparam logic [1:0] SLOT_LIVE  = 2'b10;

   typedef struct packed {
      logic       load;
      logic       hash_step;
      logic [2:0] step_idx;
      logic       init;
      logic       pload;
      logic       mod_step;
      logic       rd;
      logic       eval;
      logic       fin;
      logic       clear;
      logic       rsp_load;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic stop;
      logic last_probe;
      logic noop;
   } sts_type;

   function automatic logic [31:0] asr(input logic [31:0] a, input int unsigned n);
      asr = 32'($signed(a) >>> n);
   endfunction

   function automatic logic [31:0] mix_first_step(input logic [31:0] a,
                                                  input logic [2:0] k);
      logic [31:0] r;
      case (k)
         3'd0: r = a + ~(a << 15);
         3'd1: r = a ^ asr(a, 10);
         3'd2: r = a + (a << 3);
         3'd3: r = a ^ asr(a, 6);
         3'd4: r = a + ~(a << 11);
         3'd5: r = a ^ asr(a, 16);
         default: r = a;
      endcase
      return r;
   endfunction

   function automatic logic [31:0] mix_second_step(input logic [31:0] a,
                                                   input logic [2:0] k);
      logic [31:0] r;
      case (k)
         3'd0: r = a + MIX_C0 + (a << 12);
         3'd1: r = a ^ MIX_C1 ^ asr(a, 19);
         3'd2: r = a + MIX_C2 + (a << 5);
         3'd3: r = (a + MIX_C3) ^ (a << 9);
         3'd4: r = a + MIX_C4 + (a << 3);
         3'd5: r = a ^ MIX_C5 ^ asr(a, 16);
         default: r = a;
      endcase
      return r;
   endfunction

endpackage

// ----- design/dhoat_dp.sv -----
module dhoat_dp #(
   parameter int TABLE_SLOTS = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dhoat_pkg::cmd_type    cmd,
   output dhoat_pkg::sts_type    sts,
   input  logic [1:0]            req_type,
   input  logic signed [31:0]    req_key,
   input  logic signed [31:0]    req_value,
   output logic [2:0]            rsp_status,
   output logic signed [31:0]    rsp_found_value,
   output logic [10:0]           rsp_free_slots
);

   localparam int IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int CW = $clog2(TABLE_SLOTS + 1);
   localparam int FW = (CW > 11) ? CW : 11;

   // ceil(2^(32+IW) / TABLE_SLOTS), 33 bits; exact quotient for any 32-bit magnitude
   localparam logic [63:0] RECIP = ((64'd1 << (32 + IW)) + 64'(TABLE_SLOTS) - 64'd1) /
                                   64'(TABLE_SLOTS);
   localparam logic [31:0] RECIP_LO = RECIP[31:0];
   localparam logic        RECIP_HI = RECIP[32];

   logic [1:0]  state_mem [TABLE_SLOTS];
   logic [31:0] key_mem   [TABLE_SLOTS];
   logic [31:0] val_mem   [TABLE_SLOTS];

   logic [1:0]    type_ff;
   logic [31:0]   key_ff, val_ff;
   logic [31:0]   h1_ff, h2_ff, delta_ff, t_ff;
   logic [31:0]   sh_ff;
   logic [64:0]   prod_ff, prod_in;
   logic [IW-1:0] r_ff, r_in;
   logic [CW-1:0] i_ff;
   logic [IW-1:0] clr_ff;
   logic [CW-1:0] free_ff;
   logic          have_free_ff, match_ff;
   logic [IW-1:0] free_idx_ff;
   logic [31:0]   found_ff;
   logic [1:0]    rd_state_ff;
   logic [31:0]   rd_key_ff, rd_val_ff;
   logic [2:0]    status_ff;
   logic [2:0]    rsp_status_ff;
   logic [31:0]   rsp_found_ff;
   logic [10:0]   rsp_free_ff;
   logic [FW-1:0] free_ext;

   logic used, tomb, hit, empty_end;
   logic [32-IW:0] quo;
   logic [31:0]    quo_n;
   logic [31:0]    mag;

   assign used      = rd_state_ff[1];
   assign tomb      = rd_state_ff[0];
   assign hit       = used && (rd_key_ff == key_ff);
   assign empty_end = !used && !tomb;
   assign mag       = t_ff[31] ? (32'd0 - t_ff) : t_ff;

   assign sts.clr_last   = (clr_ff == IW'(TABLE_SLOTS - 1));
   assign sts.stop       = hit || empty_end;
   assign sts.last_probe = (i_ff == CW'(TABLE_SLOTS - 1));
   assign sts.noop       = (type_ff != dhoat_pkg::REQ_INSERT) &&
                           (type_ff != dhoat_pkg::REQ_DELETE) &&
                           (type_ff != dhoat_pkg::REQ_SEARCH);

   // remainder by the table size: quotient from the reciprocal product, then subtract
   assign prod_in = 65'(64'(sh_ff) * 64'(RECIP_LO)) +
                    (RECIP_HI ? {1'b0, sh_ff, 32'd0} : 65'd0);
   assign quo     = prod_ff[64:32+IW];
   assign quo_n   = 32'(quo) * 32'(TABLE_SLOTS);
   assign r_in    = IW'(sh_ff - quo_n);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         type_ff <= req_type;
         key_ff  <= req_key;
         val_ff  <= req_value;
         h1_ff   <= req_key;
         h2_ff   <= req_key;
      end
      if (cmd.hash_step) begin
         h1_ff <= dhoat_pkg::mix_first_step(h1_ff, cmd.step_idx);
         h2_ff <= dhoat_pkg::mix_second_step(h2_ff, cmd.step_idx);
      end
      if (cmd.init) begin
         t_ff         <= h1_ff;
         delta_ff     <= h2_ff - 32'd1;
         i_ff         <= '0;
         have_free_ff <= 1'b0;
         match_ff     <= 1'b0;
         found_ff     <= '0;
      end
      if (cmd.pload) begin
         sh_ff <= mag;
         r_ff  <= '0;
      end
      // product settles in the first step, remainder is valid after the second
      if (cmd.mod_step) begin
         prod_ff <= prod_in;
         r_ff    <= r_in;
      end
      if (cmd.rd) begin
         rd_state_ff <= state_mem[r_ff];
         rd_key_ff   <= key_mem[r_ff];
         rd_val_ff   <= val_mem[r_ff];
      end
      if (cmd.eval) begin
         t_ff <= t_ff + delta_ff;
         i_ff <= i_ff + CW'(1);
         if (hit) begin
            match_ff <= 1'b1;
            unique case (type_ff)
               dhoat_pkg::REQ_INSERT: val_mem[r_ff] <= val_ff;
               dhoat_pkg::REQ_DELETE: state_mem[r_ff] <= dhoat_pkg::SLOT_TOMB;
               default: found_ff <= rd_val_ff;
            endcase
         end else if (!used && !have_free_ff) begin
            have_free_ff <= 1'b1;
            free_idx_ff  <= r_ff;
         end
      end
      if (cmd.fin) begin
         if (type_ff == dhoat_pkg::REQ_INSERT && !match_ff && have_free_ff) begin
            state_mem[free_idx_ff] <= dhoat_pkg::SLOT_LIVE;
            key_mem[free_idx_ff]   <= key_ff;
            val_mem[free_idx_ff]   <= val_ff;
         end
         unique case (type_ff)
            dhoat_pkg::REQ_INSERT:
               status_ff <= match_ff ? dhoat_pkg::ST_UPDATED :
                            have_free_ff ? dhoat_pkg::ST_INSERTED : dhoat_pkg::ST_FULL;
            dhoat_pkg::REQ_DELETE:
               status_ff <= match_ff ? dhoat_pkg::ST_DELETED : dhoat_pkg::ST_NOTFOUND;
            dhoat_pkg::REQ_SEARCH:
               status_ff <= match_ff ? dhoat_pkg::ST_FOUND : dhoat_pkg::ST_NOTFOUND;
            default: status_ff <= dhoat_pkg::ST_NOTFOUND;
         endcase
      end
      if (cmd.clear) begin
         state_mem[clr_ff] <= dhoat_pkg::SLOT_EMPTY;
      end
      if (cmd.rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_found_ff  <= found_ff;
         rsp_free_ff   <= free_ext[10:0];
      end
   end

   assign free_ext = FW'(free_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff  <= '0;
         free_ff <= CW'(TABLE_SLOTS);
      end else begin
         if (cmd.clear) begin
            clr_ff <= clr_ff + IW'(1);
         end
         if (cmd.eval && hit && type_ff == dhoat_pkg::REQ_DELETE &&
             free_ff != CW'(TABLE_SLOTS)) begin
            free_ff <= free_ff + CW'(1);
         end else if (cmd.fin && type_ff == dhoat_pkg::REQ_INSERT && !match_ff &&
                      have_free_ff && free_ff != '0) begin
            free_ff <= free_ff - CW'(1);
         end
      end
   end

   assign rsp_status      = rsp_status_ff;
   assign rsp_found_value = rsp_found_ff;
   assign rsp_free_slots  = rsp_free_ff;

endmodule

// ----- design/dhoat_ctrl.sv -----
module dhoat_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output dhoat_pkg::cmd_type cmd,
   input  dhoat_pkg::sts_type sts
);

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_HASH  = 4'd2;
   localparam logic [3:0] S_INIT  = 4'd3;
   localparam logic [3:0] S_PLOAD = 4'd4;
   localparam logic [3:0] S_MOD   = 4'd5;
   localparam logic [3:0] S_READ  = 4'd6;
   localparam logic [3:0] S_EVAL  = 4'd7;
   localparam logic [3:0] S_FIN   = 4'd8;
   localparam logic [3:0] S_DONE  = 4'd9;

   logic [3:0] state_ff, state_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cmd          = '0;
      cmd.step_idx = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = S_HASH;
            end
         end
         S_HASH: begin
            cmd.hash_step = 1'b1;
            cnt_in        = cnt_ff + 3'd1;
            if (cnt_ff == 3'(dhoat_pkg::HASH_STEPS - 1)) state_in = S_INIT;
         end
         S_INIT: begin
            cmd.init = 1'b1;
            state_in = sts.noop ? S_FIN : S_PLOAD;
         end
         S_PLOAD: begin
            cmd.pload = 1'b1;
            cnt_in    = '0;
            state_in  = S_MOD;
         end
         S_MOD: begin
            cmd.mod_step = 1'b1;
            cnt_in       = cnt_ff + 3'd1;
            if (cnt_ff == 3'(dhoat_pkg::MOD_STEPS - 1)) state_in = S_READ;
         end
         S_READ: begin
            cmd.rd   = 1'b1;
            state_in = S_EVAL;
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            state_in = (sts.stop || sts.last_probe) ? S_FIN : S_PLOAD;
         end
         S_FIN: begin
            cmd.fin  = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- design/double_hash_open_address_table_top.sv -----
// channel  | ports                                    | beat taken when
// request  | req_type, req_key, req_value             | req_valid && req_ready
// response | rsp_status, rsp_found_value, rsp_free_slots | rsp_valid && rsp_ready
//
// After reset a clearing pass over all TABLE_SLOTS slots empties the slot marks; no
// request is taken until it ends. A request with P probes (none for an unknown type)
// runs through accept, six hash steps and one setup step, then per probe a load, a
// remainder by the table size via a reciprocal multiply (product, then subtraction),
// one memory read and one evaluation, then finish and a response load that waits for
// a free output register, raising rsp_valid. One request is in flight at a time; a
// finished response waits in the output register while the next request is accepted.
module double_hash_open_address_table_top #(
   parameter int TABLE_SLOTS = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_type,
   input  logic signed [31:0] req_key,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_status,
   output logic signed [31:0] rsp_found_value,
   output logic [10:0]        rsp_free_slots
);

   dhoat_pkg::cmd_type cmd;
   dhoat_pkg::sts_type sts;

   dhoat_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   dhoat_dp #(
      .TABLE_SLOTS (TABLE_SLOTS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_type        (req_type),
      .req_key         (req_key),
      .req_value       (req_value),
      .rsp_status      (rsp_status),
      .rsp_found_value (rsp_found_value),
      .rsp_free_slots  (rsp_free_slots)
   );

endmodule
